// File: rtl/mdc_pkg.sv
// Shared types, codes and the direction order table of the depth-first maze carver.
package mdc_pkg;

   localparam int CFG_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int ORDER_W    = 5;
   localparam int KIND_W     = 3;
   localparam int FIELD_W    = 6;
   localparam int DEPTH_W    = 11;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 8;

   localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 7'd16;
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 7'd16;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_STEP    = 1'b1;

   localparam logic [KIND_W-1:0] KIND_STARTED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CARVED      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BACKTRACKED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FINISHED    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEGENERATE  = 3'd4;

   typedef logic [1:0] dir_type;

   localparam dir_type DIR_PX = 2'd0;
   localparam dir_type DIR_MX = 2'd1;
   localparam dir_type DIR_PY = 2'd2;
   localparam dir_type DIR_MY = 2'd3;

   typedef logic [7:0] order_type;

   // Lexicographic permutations of the four directions; the first direction to
   // try sits in the low two bits. Codes 24 to 31 wrap onto 0 to 7.
   localparam order_type ORDER_TABLE [32] = '{
      {DIR_MY, DIR_PY, DIR_MX, DIR_PX}, {DIR_PY, DIR_MY, DIR_MX, DIR_PX},
      {DIR_MY, DIR_MX, DIR_PY, DIR_PX}, {DIR_MX, DIR_MY, DIR_PY, DIR_PX},
      {DIR_PY, DIR_MX, DIR_MY, DIR_PX}, {DIR_MX, DIR_PY, DIR_MY, DIR_PX},
      {DIR_MY, DIR_PY, DIR_PX, DIR_MX}, {DIR_PY, DIR_MY, DIR_PX, DIR_MX},
      {DIR_MY, DIR_PX, DIR_PY, DIR_MX}, {DIR_PX, DIR_MY, DIR_PY, DIR_MX},
      {DIR_PY, DIR_PX, DIR_MY, DIR_MX}, {DIR_PX, DIR_PY, DIR_MY, DIR_MX},
      {DIR_MY, DIR_MX, DIR_PX, DIR_PY}, {DIR_MX, DIR_MY, DIR_PX, DIR_PY},
      {DIR_MY, DIR_PX, DIR_MX, DIR_PY}, {DIR_PX, DIR_MY, DIR_MX, DIR_PY},
      {DIR_MX, DIR_PX, DIR_MY, DIR_PY}, {DIR_PX, DIR_MX, DIR_MY, DIR_PY},
      {DIR_PY, DIR_MX, DIR_PX, DIR_MY}, {DIR_MX, DIR_PY, DIR_PX, DIR_MY},
      {DIR_PY, DIR_PX, DIR_MX, DIR_MY}, {DIR_PX, DIR_PY, DIR_MX, DIR_MY},
      {DIR_MX, DIR_PX, DIR_PY, DIR_MY}, {DIR_PX, DIR_MX, DIR_PY, DIR_MY},
      {DIR_MY, DIR_PY, DIR_MX, DIR_PX}, {DIR_PY, DIR_MY, DIR_MX, DIR_PX},
      {DIR_MY, DIR_MX, DIR_PY, DIR_PX}, {DIR_MX, DIR_MY, DIR_PY, DIR_PX},
      {DIR_PY, DIR_MX, DIR_MY, DIR_PX}, {DIR_MX, DIR_PY, DIR_MY, DIR_PX},
      {DIR_MY, DIR_PY, DIR_PX, DIR_MX}, {DIR_PY, DIR_MY, DIR_PX, DIR_MX}
   };

   function automatic dir_type order_dir(input logic [ORDER_W-1:0] order,
                                         input logic [1:0] slot);
      order_type entry;
      entry = ORDER_TABLE[order];
      return entry[{slot, 1'b0} +: 2];
   endfunction

endpackage

// File: rtl/mdc_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module mdc_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/maze_depth_first_carver.sv
// Depth-first maze carver: sequencer around the cell memory and the path stack memory.
//
// Each request item is one command: a restart, or one step of a randomized depth-first
// search whose direction order comes in with the item; each item yields exactly one
// result item. The maze lives in an on-chip memory with one open bit per cell, and the
// search path in a stack memory; the stack top is also kept in registers. A step that
// finds the search ended or the grid all open goes straight to the result; otherwise
// the sequencer accepts the item, then for each direction tried checks the bounds and,
// when the target lies inside the grid, reads the cell memory and checks the bit,
// then writes the opened cells (carve) or pops the stack (backtrack), and hands the
// result to the output register. A restart on a grid of at least 3 by 3 sweeps the
// whole cell memory back to wall, one cell per cycle, then opens the start cell; a
// restart on a smaller grid skips the sweep. The result register lets the next
// request item be taken while a result still waits on the output side.
module maze_depth_first_carver
   import mdc_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] order_index, [7:5] zero
   input  logic                  req_tuser,   // [0] cmd
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] cell_x, [11:6] cell_y,
                                              // [17:12] wall_x, [23:18] wall_y,
                                              // [34:24] depth, [39:35] zero
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [2:0] kind, [7:3] zero
   // Register writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int XDW  = XW + 1;
   localparam int YDW  = YW + 1;
   localparam int GAW  = XW + YW;
   localparam int SD   = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2);
   localparam int SAW  = $clog2(SD);
   localparam int CNTW = $clog2(SD + 1);
   localparam int CMPX = (XDW > CFG_W) ? XDW : CFG_W;
   localparam int CMPY = (YDW > CFG_W) ? YDW : CFG_W;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CLEAR     = 4'd1;
   localparam logic [3:0] ST_START     = 4'd2;
   localparam logic [3:0] ST_PROBE     = 4'd3;
   localparam logic [3:0] ST_CHECK     = 4'd4;
   localparam logic [3:0] ST_CARVE_MID = 4'd5;
   localparam logic [3:0] ST_CARVE_FAR = 4'd6;
   localparam logic [3:0] ST_POP       = 4'd7;
   localparam logic [3:0] ST_POP_DONE  = 4'd8;
   localparam logic [3:0] ST_EMIT      = 4'd9;

   // Configuration registers.
   logic [CFG_W-1:0] grid_width_ff, grid_height_ff;

   // Sequencer state.
   logic [3:0]         state_ff, state_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [1:0]         slot_ff, slot_in;
   logic [XW-1:0]      top_x_ff, top_x_in;
   logic [YW-1:0]      top_y_ff, top_y_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic               degen_ff, degen_in;
   logic [GAW-1:0]     clr_ff, clr_in;
   logic [XW-1:0]      far_x_ff, far_x_in, mid_x_ff, mid_x_in;
   logic [YW-1:0]      far_y_ff, far_y_in, mid_y_ff, mid_y_in;

   // Staged result.
   logic [KIND_W-1:0]  res_kind_ff, res_kind_in;
   logic [XW-1:0]      res_cx_ff, res_cx_in, res_wx_ff, res_wx_in;
   logic [YW-1:0]      res_cy_ff, res_cy_in, res_wy_ff, res_wy_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   // Memory ports.
   logic           grid_we, grid_re, grid_wdata, grid_rdata;
   logic [GAW-1:0] grid_waddr, grid_raddr;
   logic           stk_we, stk_re;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [GAW-1:0] stk_wdata, stk_rdata;

   // Derived values.
   logic [CMPX-1:0] gw_ext;
   logic [CMPY-1:0] gh_ext;
   logic [XDW-1:0]  eff_w;
   logic [YDW-1:0]  eff_h;
   logic            small_grid;
   logic [XW-1:0]   start_x;
   logic [YW-1:0]   start_y;
   dir_type         dir;
   logic            nb_in_bounds;
   logic            x_cur_ok, y_cur_ok;
   logic [XW-1:0]   nb_far_x, nb_mid_x;
   logic [YW-1:0]   nb_far_y, nb_mid_y;
   logic [CNTW-1:0] cnt_m1, cnt_m2;
   logic            out_free;
   logic            req_accept;

   mdc_ram #(.ADDR_W(GAW), .DATA_W(1)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_en   (grid_re),
      .rd_addr (grid_raddr),
      .rd_data (grid_rdata)
   );

   mdc_ram #(.ADDR_W(SAW), .DATA_W(GAW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_kind_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_GRID_WIDTH) begin
            grid_width_ff <= csr_data;
         end
         if (csr_index == REG_GRID_HEIGHT) begin
            grid_height_ff <= csr_data;
         end
      end
   end

   // Grid size in use, clamped to the memory's dimensions.
   always_comb begin
      gw_ext     = CMPX'(grid_width_ff);
      gh_ext     = CMPY'(grid_height_ff);
      eff_w      = (gw_ext > CMPX'(MAX_WIDTH)) ? XDW'(MAX_WIDTH) : XDW'(gw_ext);
      eff_h      = (gh_ext > CMPY'(MAX_HEIGHT)) ? YDW'(MAX_HEIGHT) : YDW'(gh_ext);
      small_grid = (eff_w < XDW'(3)) || (eff_h < YDW'(3));
      start_x    = XW'(!eff_w[0]);
      start_y    = YW'(!eff_h[0]);
   end

   // Neighbor two cells away from the stack top in the direction under test. The grid
   // may have shrunk under the path, so both coordinates of the target are checked.
   always_comb begin
      dir          = order_dir(order_ff, slot_ff);
      x_cur_ok     = {1'b0, top_x_ff} < eff_w;
      y_cur_ok     = {1'b0, top_y_ff} < eff_h;
      nb_far_x     = top_x_ff;
      nb_mid_x     = top_x_ff;
      nb_far_y     = top_y_ff;
      nb_mid_y     = top_y_ff;
      nb_in_bounds = 1'b0;
      unique case (dir)
         DIR_PX: begin
            nb_far_x     = top_x_ff + XW'(2);
            nb_mid_x     = top_x_ff + XW'(1);
            nb_in_bounds = (({2'b00, top_x_ff} + (XW + 2)'(2)) < {1'b0, eff_w}) &&
                           y_cur_ok;
         end
         DIR_MX: begin
            nb_far_x     = top_x_ff - XW'(2);
            nb_mid_x     = top_x_ff - XW'(1);
            nb_in_bounds = (top_x_ff >= XW'(2)) && ({1'b0, nb_far_x} < eff_w) &&
                           y_cur_ok;
         end
         DIR_PY: begin
            nb_far_y     = top_y_ff + YW'(2);
            nb_mid_y     = top_y_ff + YW'(1);
            nb_in_bounds = (({2'b00, top_y_ff} + (YW + 2)'(2)) < {1'b0, eff_h}) &&
                           x_cur_ok;
         end
         DIR_MY: begin
            nb_far_y     = top_y_ff - YW'(2);
            nb_mid_y     = top_y_ff - YW'(1);
            nb_in_bounds = (top_y_ff >= YW'(2)) && ({1'b0, nb_far_y} < eff_h) &&
                           x_cur_ok;
         end
         default: begin
            nb_in_bounds = 1'b0;
         end
      endcase
   end

   assign cnt_m1 = cnt_ff - CNTW'(1);
   assign cnt_m2 = cnt_ff - CNTW'(2);

   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      slot_in      = slot_ff;
      top_x_in     = top_x_ff;
      top_y_in     = top_y_ff;
      cnt_in       = cnt_ff;
      degen_in     = degen_ff;
      clr_in       = clr_ff;
      far_x_in     = far_x_ff;
      far_y_in     = far_y_ff;
      mid_x_in     = mid_x_ff;
      mid_y_in     = mid_y_ff;
      res_kind_in  = res_kind_ff;
      res_cx_in    = res_cx_ff;
      res_cy_in    = res_cy_ff;
      res_wx_in    = res_wx_ff;
      res_wy_in    = res_wy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;

      grid_we    = 1'b0;
      grid_waddr = {far_y_ff, far_x_ff};
      grid_wdata = 1'b1;
      grid_re    = 1'b0;
      grid_raddr = {nb_far_y, nb_far_x};
      stk_we     = 1'b0;
      stk_waddr  = cnt_ff[SAW-1:0];
      stk_wdata  = {far_y_ff, far_x_ff};
      stk_re     = 1'b0;
      stk_raddr  = cnt_m2[SAW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               order_in    = req_tdata[ORDER_W-1:0];
               slot_in     = 2'd0;
               res_kind_in = KIND_FINISHED;
               res_cx_in   = '0;
               res_cy_in   = '0;
               res_wx_in   = '0;
               res_wy_in   = '0;
               if (req_tuser == CMD_RESTART) begin
                  cnt_in = '0;
                  if (small_grid) begin
                     degen_in    = 1'b1;
                     res_kind_in = KIND_DEGENERATE;
                     state_in    = ST_EMIT;
                  end else begin
                     degen_in = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
               end else if (degen_ff) begin
                  res_kind_in = KIND_DEGENERATE;
                  state_in    = ST_EMIT;
               end else if (cnt_ff == '0) begin
                  state_in = ST_EMIT;
               end else if (cnt_ff == CNTW'(SD)) begin
                  state_in = ST_POP;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_ff;
            grid_wdata = 1'b0;
            clr_in     = clr_ff + GAW'(1);
            if (clr_ff == '1) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            grid_we     = 1'b1;
            grid_waddr  = {start_y, start_x};
            stk_we      = 1'b1;
            stk_waddr   = '0;
            stk_wdata   = {start_y, start_x};
            top_x_in    = start_x;
            top_y_in    = start_y;
            cnt_in      = CNTW'(1);
            res_kind_in = KIND_STARTED;
            res_cx_in   = start_x;
            res_cy_in   = start_y;
            state_in    = ST_EMIT;
         end
         ST_PROBE: begin
            if (nb_in_bounds) begin
               grid_re  = 1'b1;
               far_x_in = nb_far_x;
               far_y_in = nb_far_y;
               mid_x_in = nb_mid_x;
               mid_y_in = nb_mid_y;
               state_in = ST_CHECK;
            end else if (slot_ff == 2'd3) begin
               state_in = ST_POP;
            end else begin
               slot_in = slot_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            // The memory holds an open bit: zero means the far cell is still wall.
            if (!grid_rdata) begin
               state_in = ST_CARVE_MID;
            end else if (slot_ff == 2'd3) begin
               state_in = ST_POP;
            end else begin
               slot_in  = slot_ff + 2'd1;
               state_in = ST_PROBE;
            end
         end
         ST_CARVE_MID: begin
            grid_we    = 1'b1;
            grid_waddr = {mid_y_ff, mid_x_ff};
            state_in   = ST_CARVE_FAR;
         end
         ST_CARVE_FAR: begin
            grid_we     = 1'b1;
            stk_we      = 1'b1;
            top_x_in    = far_x_ff;
            top_y_in    = far_y_ff;
            cnt_in      = cnt_ff + CNTW'(1);
            res_kind_in = KIND_CARVED;
            res_cx_in   = far_x_ff;
            res_cy_in   = far_y_ff;
            res_wx_in   = mid_x_ff;
            res_wy_in   = mid_y_ff;
            state_in    = ST_EMIT;
         end
         ST_POP: begin
            cnt_in = cnt_m1;
            if (cnt_ff == CNTW'(1)) begin
               state_in = ST_EMIT;
            end else begin
               stk_re   = 1'b1;
               state_in = ST_POP_DONE;
            end
         end
         ST_POP_DONE: begin
            top_x_in    = stk_rdata[XW-1:0];
            top_y_in    = stk_rdata[GAW-1:XW];
            res_kind_in = KIND_BACKTRACKED;
            res_cx_in   = stk_rdata[XW-1:0];
            res_cy_in   = stk_rdata[GAW-1:XW];
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_data_in  = {5'b0_0000, DEPTH_W'(cnt_ff),
                               FIELD_W'(res_wy_ff), FIELD_W'(res_wx_ff),
                               FIELD_W'(res_cy_ff), FIELD_W'(res_cx_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         degen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         degen_ff     <= degen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff    <= order_in;
      slot_ff     <= slot_in;
      top_x_ff    <= top_x_in;
      top_y_ff    <= top_y_in;
      clr_ff      <= clr_in;
      far_x_ff    <= far_x_in;
      far_y_ff    <= far_y_in;
      mid_x_ff    <= mid_x_in;
      mid_y_ff    <= mid_y_in;
      res_kind_ff <= res_kind_in;
      res_cx_ff   <= res_cx_in;
      res_cy_ff   <= res_cy_in;
      res_wx_ff   <= res_wx_in;
      res_wy_ff   <= res_wy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

endmodule

// File: tb/maze_depth_first_carver_tb.sv
// Self-checking testbench for the depth-first maze carver: directed and random restarts and steps.
`timescale 1ns / 1ps

module maze_depth_first_carver_tb;
   import mdc_pkg::*;

   localparam int GRID_MAX     = 64;
   localparam int PATH_SLOTS   = 1024;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 700;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] cell_x;
      logic [FIELD_W-1:0] cell_y;
      logic [FIELD_W-1:0] wall_x;
      logic [FIELD_W-1:0] wall_y;
      logic [DEPTH_W-1:0] depth;
   } maze_move_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_data = '0;

   maze_depth_first_carver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Mirror of the maze, the search path and the grid registers.
   bit                 wall_map [GRID_MAX*GRID_MAX];
   logic [FIELD_W-1:0] path_x [PATH_SLOTS];
   logic [FIELD_W-1:0] path_y [PATH_SLOTS];
   int                 path_len = 0;
   bit                 maze_all_open = 1'b0;
   logic [CFG_W-1:0]   grid_w_reg = GRID_WIDTH_RESET;
   logic [CFG_W-1:0]   grid_h_reg = GRID_HEIGHT_RESET;

   maze_move_type expected_moves [$];

   bit   steady = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   items_sent = 0;
   int   restarts_sent = 0;
   int   config_writes = 0;
   int   random_items = 0;
   int   deepest_path = 0;
   int   kind_seen [8];

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (int n = 0; n < GRID_MAX*GRID_MAX; n++) wall_map[n] = 1'b1;
      for (int n = 0; n < 8; n++) kind_seen[n] = 0;
   end

   // Turns a permutation number into four directions, first to try in the low bits.
   function automatic logic [7:0] order_to_dirs(input logic [ORDER_W-1:0] code);
      dir_type    pool [4];
      logic [7:0] seq;
      int         rem, fact, left, pick, i, j;
      pool[0] = DIR_PX;
      pool[1] = DIR_MX;
      pool[2] = DIR_PY;
      pool[3] = DIR_MY;
      rem = code % 24;
      fact = 6;
      left = 4;
      seq = '0;
      for (i = 0; i < 4; i++) begin
         pick = rem / fact;
         rem = rem % fact;
         seq[2*i +: 2] = pool[pick];
         for (j = pick; j < left - 1; j++) pool[j] = pool[j + 1];
         left--;
         if (left > 0) fact = fact / left;
      end
      return seq;
   endfunction

   function automatic maze_move_type predict_maze_step(input logic cmd,
                                                       input logic [ORDER_W-1:0] order);
      maze_move_type move;
      logic [7:0]    tries;
      dir_type       d;
      int            w, h, cx, cy, nx, ny, mx, my, dx, dy, i, n;
      bit            carved;
      move = '0;
      w = (grid_w_reg > GRID_MAX) ? GRID_MAX : int'(grid_w_reg);
      h = (grid_h_reg > GRID_MAX) ? GRID_MAX : int'(grid_h_reg);
      if (cmd == CMD_RESTART) begin
         path_len = 0;
         if (w < 3 || h < 3) begin
            for (n = 0; n < GRID_MAX*GRID_MAX; n++) wall_map[n] = 1'b0;
            maze_all_open = 1'b1;
            move.kind = KIND_DEGENERATE;
         end else begin
            maze_all_open = 1'b0;
            for (n = 0; n < GRID_MAX*GRID_MAX; n++) wall_map[n] = 1'b1;
            cx = (w % 2 == 0) ? 1 : 0;
            cy = (h % 2 == 0) ? 1 : 0;
            wall_map[cy*GRID_MAX + cx] = 1'b0;
            path_x[0] = FIELD_W'(cx);
            path_y[0] = FIELD_W'(cy);
            path_len = 1;
            move.kind = KIND_STARTED;
            move.cell_x = FIELD_W'(cx);
            move.cell_y = FIELD_W'(cy);
         end
      end else if (maze_all_open) begin
         move.kind = KIND_DEGENERATE;
      end else if (path_len == 0) begin
         move.kind = KIND_FINISHED;
      end else begin
         cx = int'(path_x[path_len - 1]);
         cy = int'(path_y[path_len - 1]);
         tries = order_to_dirs(order);
         carved = 1'b0;
         // A full path cannot take another cell, so the step falls back to a pop.
         for (i = 0; i < 4 && !carved && path_len < PATH_SLOTS; i++) begin
            d = tries[2*i +: 2];
            dx = 0;
            dy = 0;
            case (d)
               DIR_PX: dx = 1;
               DIR_MX: dx = -1;
               DIR_PY: dy = 1;
               default: dy = -1;
            endcase
            nx = cx + 2*dx;
            ny = cy + 2*dy;
            mx = cx + dx;
            my = cy + dy;
            if (nx >= 0 && ny >= 0 && nx < w && ny < h && wall_map[ny*GRID_MAX + nx]) begin
               wall_map[my*GRID_MAX + mx] = 1'b0;
               wall_map[ny*GRID_MAX + nx] = 1'b0;
               path_x[path_len] = FIELD_W'(nx);
               path_y[path_len] = FIELD_W'(ny);
               path_len++;
               move.kind = KIND_CARVED;
               move.cell_x = FIELD_W'(nx);
               move.cell_y = FIELD_W'(ny);
               move.wall_x = FIELD_W'(mx);
               move.wall_y = FIELD_W'(my);
               carved = 1'b1;
            end
         end
         if (!carved) begin
            path_len--;
            if (path_len == 0) begin
               move.kind = KIND_FINISHED;
            end else begin
               move.kind = KIND_BACKTRACKED;
               move.cell_x = path_x[path_len - 1];
               move.cell_y = path_y[path_len - 1];
            end
         end
      end
      move.depth = DEPTH_W'(path_len);
      return move;
   endfunction

   task automatic send_request(input logic cmd, input logic [ORDER_W-1:0] order);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{(REQ_DATA_W-ORDER_W){1'b0}}, order};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_moves.insert(expected_moves.size(), predict_maze_step(cmd, order));
      items_sent++;
      if (cmd == CMD_RESTART) restarts_sent++;
   endtask

   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
   endtask

   // Writes width then height; valid stays high across the two items.
   task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      csr_valid <= 1'b1;
      csr_index <= REG_GRID_WIDTH;
      csr_data <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      grid_w_reg = w;
      csr_index <= REG_GRID_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      grid_h_reg = h;
      csr_valid <= 1'b0;
      config_writes += 2;
   endtask

   task automatic note_mismatch(input string what, input maze_move_type want,
                                input maze_move_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("ERROR at %0t: %s", $realtime, what);
         $display("   expected kind %0d cell (%0d,%0d) wall (%0d,%0d) depth %0d",
                  want.kind, want.cell_x, want.cell_y, want.wall_x, want.wall_y, want.depth);
         $display("   actual   kind %0d cell (%0d,%0d) wall (%0d,%0d) depth %0d pad %0h/%0h",
                  got.kind, got.cell_x, got.cell_y, got.wall_x, got.wall_y, got.depth,
                  rsp_tdata[RSP_DATA_W-1:35], rsp_tuser[RSP_USER_W-1:KIND_W]);
      end
   endtask

   // Result side: checks each accepted item and drives tready, with a counted hold-off.
   always @(posedge clock) begin
      maze_move_type got;
      maze_move_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser[KIND_W-1:0];
            got.cell_x = rsp_tdata[5:0];
            got.cell_y = rsp_tdata[11:6];
            got.wall_x = rsp_tdata[17:12];
            got.wall_y = rsp_tdata[23:18];
            got.depth = rsp_tdata[34:24];
            kind_seen[got.kind]++;
            if (got.depth > deepest_path) deepest_path = int'(got.depth);
            if (expected_moves.size() == 0) begin
               note_mismatch("result item with no expectation waiting", '0, got);
            end else begin
               want = expected_moves.pop_front();
               if (got.kind !== want.kind || got.cell_x !== want.cell_x ||
                   got.cell_y !== want.cell_y || got.wall_x !== want.wall_x ||
                   got.wall_y !== want.wall_y || got.depth !== want.depth ||
                   rsp_tdata[RSP_DATA_W-1:35] !== '0 ||
                   rsp_tuser[RSP_USER_W-1:KIND_W] !== '0) begin
                  note_mismatch("result item differs", want, got);
               end
            end
         end
         if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_empty_path;
      send_request(CMD_STEP, 5'd0);
      send_request(CMD_STEP, 5'd31);
      wait_for_results();
   endtask

   task automatic test_small_grids;
      set_grid(7'd2, 7'd64);
      send_request(CMD_RESTART, 5'd0);
      send_request(CMD_STEP, 5'd10);
      wait_for_results();
      set_grid(7'd64, 7'd0);
      send_request(CMD_RESTART, 5'd0);
      wait_for_results();
      set_grid(7'd1, 7'd1);
      send_request(CMD_RESTART, 5'd21);
      send_request(CMD_STEP, 5'd23);
      wait_for_results();
   endtask

   // A 3 by 3 grid has four cells on the path lattice, so the walk ends quickly
   // and the last pop plus the steps after it report finished.
   task automatic test_tiny_maze;
      int k;
      set_grid(7'd3, 7'd3);
      send_request(CMD_RESTART, 5'd0);
      for (k = 24; k < 32; k++) send_request(CMD_STEP, ORDER_W'(k));
      send_request(CMD_STEP, 5'd5);
      send_request(CMD_STEP, 5'd17);
      wait_for_results();
   endtask

   task automatic test_clamp_and_resize;
      set_grid(7'd127, 7'd65);
      send_request(CMD_RESTART, 5'd0);
      send_request(CMD_STEP, 5'd1);
      send_request(CMD_STEP, 5'd12);
      send_request(CMD_STEP, 5'd20);
      wait_for_results();
      // Shrinking the width mid-search moves the bound under the current path.
      set_grid(7'd5, 7'd127);
      send_request(CMD_STEP, 5'd0);
      send_request(CMD_STEP, 5'd7);
      wait_for_results();
   endtask

   task automatic test_backpressure;
      int k;
      set_grid(7'd16, 7'd16);
      send_request(CMD_RESTART, 5'd3);
      wait_for_results();
      hold_toggle <= ~hold_toggle;
      steady = 1'b1;
      for (k = 0; k < 16; k++) send_request(CMD_STEP, ORDER_W'($urandom_range(0, 31)));
      steady = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_mazes;
      int         phase, steps, k, pick;
      logic [6:0] w, h;
      bit         biased;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               w = CFG_W'($urandom_range(0, 2));
               h = CFG_W'($urandom_range(0, 127));
               if ($urandom_range(0, 1)) {w, h} = {h, w};
            end
            1: begin
               w = CFG_W'($urandom_range(65, 127));
               h = CFG_W'($urandom_range(3, 127));
            end
            2: begin
               w = 7'd64;
               h = 7'd64;
            end
            default: begin
               w = CFG_W'($urandom_range(3, 16));
               h = CFG_W'($urandom_range(3, 16));
            end
         endcase
         if (pick == 0) steps = 3;
         else if (pick == 2) steps = $urandom_range(100, 200);
         else steps = $urandom_range(20, 70);
         // Orders 0 to 5 all try +x first, which drives the path to the far edge.
         biased = ($urandom_range(0, 3) == 0);
         steady = (phase == 2);
         set_grid(w, h);
         send_request(CMD_RESTART, ORDER_W'($urandom_range(0, 31)));
         random_items++;
         for (k = 0; k < steps && random_items < RANDOM_ITEMS; k++) begin
            if (k == steps / 2 && $urandom_range(0, 3) == 0) begin
               wait_for_results();
               set_grid(CFG_W'($urandom_range(3, 64)), CFG_W'($urandom_range(3, 64)));
            end
            if ($urandom_range(0, 99) < 2)
               send_request(CMD_RESTART, ORDER_W'($urandom_range(0, 31)));
            else if (biased)
               send_request(CMD_STEP, ORDER_W'($urandom_range(0, 5)));
            else
               send_request(CMD_STEP, ORDER_W'($urandom_range(0, 31)));
            random_items++;
         end
         wait_for_results();
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_path();
      test_small_grids();
      test_tiny_maze();
      test_clamp_and_resize();
      test_backpressure();
      test_random_mazes();
      repeat (30) @(posedge clock);
      if (expected_moves.size() != 0) begin
         $display("ERROR: %0d expected results never arrived", expected_moves.size());
         mismatches += expected_moves.size();
      end
      $display("Sent %0d request items (%0d restarts) and %0d register writes in %0d cycles.",
               items_sent, restarts_sent, config_writes, cycle_count);
      $display("Results: started %0d, carved %0d, backtracked %0d, finished %0d,",
               kind_seen[KIND_STARTED], kind_seen[KIND_CARVED], kind_seen[KIND_BACKTRACKED],
               kind_seen[KIND_FINISHED]);
      $display("   all-open %0d; deepest path %0d.",
               kind_seen[KIND_DEGENERATE], deepest_path);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
